// ===== hw/rtl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared constants and types for the range frame parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FILL_W  = 6;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned DIST_W  = 16;

    localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h55;

    localparam logic [FILL_W-1:0] FRAME_LAST_INDEX = 6'd13;
    localparam logic [FILL_W-1:0] MAX_FILL         = 6'd50;

    // frame byte positions that are kept
    localparam logic [FILL_W-1:0] IDX_ID_LO = 6'd2;
    localparam logic [FILL_W-1:0] IDX_ID_HI = 6'd3;
    localparam logic [FILL_W-1:0] IDX_RG_HI = 6'd6;
    localparam logic [FILL_W-1:0] IDX_RG_LO = 6'd7;

    localparam logic [ID_W-1:0] ID_RESET = 16'h070C;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_HEAD1 = 4'b0010,
        PH_BODY  = 4'b0100,
        PH_TAIL1 = 4'b1000
    } phase_t;

endpackage

// ===== hw/rtl/radar_range_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// radar_range_frame_parser_unit
// Byte-stream frame parser that extracts the distance from radar range frames.
// ----------------------------------------------------------------------------
// One received byte is taken per word on the input channel, at up to one word
// per clock. A frame opens with 0xAA 0xAA and closes with 0x55 0x55; when the
// second tail byte lands at frame index 13 and the little-endian id in bytes
// 2..3 matches expected_message_id, one word carrying the big-endian distance
// from bytes 6..7 leaves on the output channel. Every other byte yields no
// output word. From input accept to output valid the byte passes through one
// input register, then the per-byte parser update, which writes the parser
// state and the output register in the same clock. Input and output are
// decoupled by those registers, so a new byte is accepted while a finished
// distance waits; the input stalls only when a byte that completes a matching
// frame finds the output register still full and stalled. The id register is
// written through the cfg channel, which is always ready; write it only while
// no bytes are in flight.
module radar_range_frame_parser_unit
(
    input  logic                             clk,
    input  logic                             rst_n,

    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrfp_pkg::ID_W-1:0]        expected_message_id,

    // byte input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rrfp_pkg::BYTE_W-1:0]      rx_byte,

    // distance output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rrfp_pkg::DIST_W-1:0]      range_cm
);

    // config
    logic [rrfp_pkg::ID_W-1:0]   exp_id_reg;

    // input register
    logic                        in_v_reg;
    logic [rrfp_pkg::BYTE_W-1:0] in_byte_reg;

    // parser state
    rrfp_pkg::phase_t            phase_reg, phase_next;
    logic [rrfp_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [rrfp_pkg::BYTE_W-1:0] id_lo_reg, id_lo_next;
    logic [rrfp_pkg::BYTE_W-1:0] id_hi_reg, id_hi_next;
    logic [rrfp_pkg::BYTE_W-1:0] rg_hi_reg, rg_hi_next;
    logic [rrfp_pkg::BYTE_W-1:0] rg_lo_reg, rg_lo_next;

    // output register
    logic                        out_v_reg;
    logic [rrfp_pkg::DIST_W-1:0] dist_reg;

    // step decode
    rrfp_pkg::phase_t            ph_eff;
    logic [rrfp_pkg::FILL_W-1:0] idx_a;   // inserted header position
    logic [rrfp_pkg::FILL_W-1:0] idx_b;   // received byte position
    logic                        put_a;
    logic                        put_b;
    logic                        hit;
    logic                        do_step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg <= rrfp_pkg::ID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            exp_id_reg <= expected_message_id;
        end
    end

    // overlong frame forces a rehunt before the byte is looked at
    assign ph_eff = (fill_reg > rrfp_pkg::MAX_FILL) ? rrfp_pkg::PH_HUNT : phase_reg;

    always_comb
    begin
        phase_next = ph_eff;
        fill_next  = fill_reg;
        put_a      = 1'b0;
        put_b      = 1'b0;
        hit        = 1'b0;
        idx_a      = fill_reg + 6'd1;
        idx_b      = fill_reg + 6'd1;

        case (ph_eff)
            rrfp_pkg::PH_HUNT:
            begin
                if (in_byte_reg == rrfp_pkg::HDR_BYTE)
                begin
                    fill_next  = '0;
                    phase_next = rrfp_pkg::PH_HEAD1;
                end
            end
            rrfp_pkg::PH_HEAD1:
            begin
                // missing second header: insert one, byte goes after it
                if (in_byte_reg != rrfp_pkg::HDR_BYTE)
                begin
                    put_a = 1'b1;
                    idx_b = fill_reg + 6'd2;
                end
                put_b      = 1'b1;
                fill_next  = idx_b;
                phase_next = rrfp_pkg::PH_BODY;
            end
            rrfp_pkg::PH_BODY:
            begin
                put_b     = 1'b1;
                fill_next = idx_b;
                if (in_byte_reg == rrfp_pkg::TAIL_BYTE)
                begin
                    phase_next = rrfp_pkg::PH_TAIL1;
                end
            end
            rrfp_pkg::PH_TAIL1:
            begin
                if (in_byte_reg != rrfp_pkg::TAIL_BYTE)
                begin
                    // broken tail: byte dropped
                    phase_next = rrfp_pkg::PH_BODY;
                end
                else
                begin
                    put_b      = 1'b1;
                    fill_next  = idx_b;
                    phase_next = rrfp_pkg::PH_HUNT;
                    hit        = (idx_b == rrfp_pkg::FRAME_LAST_INDEX) &&
                                 ({id_hi_reg, id_lo_reg} == exp_id_reg);
                end
            end
            default:
            begin
                phase_next = rrfp_pkg::PH_HUNT;
            end
        endcase
    end

    // kept-byte capture; the received byte wins over the inserted header
    always_comb
    begin
        id_lo_next = id_lo_reg;
        id_hi_next = id_hi_reg;
        rg_hi_next = rg_hi_reg;
        rg_lo_next = rg_lo_reg;

        if (put_a && idx_a == rrfp_pkg::IDX_ID_LO) id_lo_next = rrfp_pkg::HDR_BYTE;
        if (put_a && idx_a == rrfp_pkg::IDX_ID_HI) id_hi_next = rrfp_pkg::HDR_BYTE;
        if (put_a && idx_a == rrfp_pkg::IDX_RG_HI) rg_hi_next = rrfp_pkg::HDR_BYTE;
        if (put_a && idx_a == rrfp_pkg::IDX_RG_LO) rg_lo_next = rrfp_pkg::HDR_BYTE;

        if (put_b && idx_b == rrfp_pkg::IDX_ID_LO) id_lo_next = in_byte_reg;
        if (put_b && idx_b == rrfp_pkg::IDX_ID_HI) id_hi_next = in_byte_reg;
        if (put_b && idx_b == rrfp_pkg::IDX_RG_HI) rg_hi_next = in_byte_reg;
        if (put_b && idx_b == rrfp_pkg::IDX_RG_LO) rg_lo_next = in_byte_reg;
    end

    // a byte advances unless it completes a frame into a full, stalled output
    assign do_step  = in_v_reg && (!hit || !out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !do_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrfp_pkg::PH_HUNT;
            fill_reg  <= '0;
            id_lo_reg <= '0;
            id_hi_reg <= '0;
            rg_hi_reg <= '0;
            rg_lo_reg <= '0;
        end
        else if (do_step)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            id_lo_reg <= id_lo_next;
            id_hi_reg <= id_hi_next;
            rg_hi_reg <= rg_hi_next;
            rg_lo_reg <= rg_lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (do_step && hit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step && hit)
        begin
            dist_reg <= {rg_hi_reg, rg_lo_reg};
        end
    end

    assign out_valid = out_v_reg;
    assign range_cm  = dist_reg;

endmodule

// ===== tb/radar_range_frame_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// radar_range_frame_parser_unit_test
// Self-checking bench for the radar range frame parser.
// ----------------------------------------------------------------------------
// Bytes go in one word at a time. A cycle-free predictor follows the parser's
// frame state and queues the distance each byte should produce. A checker pops
// one queued distance per output word. The first part drives short directed
// frames through each corner of the parser. After that come four random phases
// with different sender and receiver idling. Each random phase uses a fresh
// id. Most random traffic is well-formed frames; the rest is broken frames
// and line noise.
// ----------------------------------------------------------------------------
module radar_range_frame_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [rrfp_pkg::BYTE_W-1:0] octet_t;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word moving on any channel
    localparam int PHASE_BYTES    = 96;     // random bytes per idling phase
    localparam int SETTLE_CYCLES  = 4;      // idle margin after the last owed distance

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                          clk                 = 1'b0;
    logic                          rst_n               = 1'b0;
    logic                          cfg_valid           = 1'b0;
    logic                          cfg_ready;
    logic [rrfp_pkg::ID_W-1:0]     expected_message_id = rrfp_pkg::ID_RESET;
    logic                          in_valid            = 1'b0;
    logic                          in_stall;
    logic [rrfp_pkg::BYTE_W-1:0]   rx_byte             = '0;
    logic                          out_valid;
    logic                          out_stall           = 1'b0;
    logic [rrfp_pkg::DIST_W-1:0]   range_cm;

    radar_range_frame_parser_unit uut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .expected_message_id (expected_message_id),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .range_cm            (range_cm)
    );

    always #5ns clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    int                            gap_pct     = 0;   // chance the sender idles before a byte
    int                            stall_pct   = 0;   // chance the receiver stalls a cycle
    int                            mismatches  = 0;
    int                            bytes_sent  = 0;
    int                            idle_cycles = 0;
    logic [rrfp_pkg::DIST_W-1:0]   head_dist;

    // Frame tracker: mirrors the parser's view of the byte stream
    rrfp_pkg::phase_t              frm_phase;
    logic [rrfp_pkg::FILL_W-1:0]   frm_fill;
    logic [rrfp_pkg::BYTE_W-1:0]   frm_id_lo;
    logic [rrfp_pkg::BYTE_W-1:0]   frm_id_hi;
    logic [rrfp_pkg::BYTE_W-1:0]   frm_rg_hi;
    logic [rrfp_pkg::BYTE_W-1:0]   frm_rg_lo;
    logic [rrfp_pkg::ID_W-1:0]     frm_want_id;
    logic [rrfp_pkg::DIST_W-1:0]   pending_dist[$];   // distances still owed by the DUT

    // ------------------------------------------------------------------------
    // Frame tracker
    // ------------------------------------------------------------------------
    function automatic void keep_frame_byte(input logic [rrfp_pkg::BYTE_W-1:0] b);
        frm_fill = frm_fill + 6'd1;
        case (frm_fill)
            rrfp_pkg::IDX_ID_LO: frm_id_lo = b;
            rrfp_pkg::IDX_ID_HI: frm_id_hi = b;
            rrfp_pkg::IDX_RG_HI: frm_rg_hi = b;
            rrfp_pkg::IDX_RG_LO: frm_rg_lo = b;
            default:   ;
        endcase
    endfunction

    function automatic void track_byte(input logic [rrfp_pkg::BYTE_W-1:0] b);
        // an overlong body always sends the parser back to hunting
        if (frm_fill > rrfp_pkg::MAX_FILL)
            frm_phase = rrfp_pkg::PH_HUNT;
        case (frm_phase)
            rrfp_pkg::PH_HUNT:
                if (b == rrfp_pkg::HDR_BYTE)
                begin
                    frm_fill  = '0;
                    frm_phase = rrfp_pkg::PH_HEAD1;
                end
            rrfp_pkg::PH_HEAD1:
            begin
                // lone header: the missing 0xAA is filled in at index 1
                if (b != rrfp_pkg::HDR_BYTE)
                    keep_frame_byte(rrfp_pkg::HDR_BYTE);
                keep_frame_byte(b);
                frm_phase = rrfp_pkg::PH_BODY;
            end
            rrfp_pkg::PH_BODY:
            begin
                keep_frame_byte(b);
                if (b == rrfp_pkg::TAIL_BYTE)
                    frm_phase = rrfp_pkg::PH_TAIL1;
            end
            default:
                if (b != rrfp_pkg::TAIL_BYTE)
                    frm_phase = rrfp_pkg::PH_BODY;    // broken tail, byte dropped
                else
                begin
                    keep_frame_byte(b);
                    frm_phase = rrfp_pkg::PH_HUNT;
                    if (frm_fill == rrfp_pkg::FRAME_LAST_INDEX &&
                        {frm_id_hi, frm_id_lo} == frm_want_id)
                        pending_dist.push_back({frm_rg_hi, frm_rg_lo});
                end
        endcase
    endfunction

    // random byte that can never be taken as a tail byte
    function automatic logic [rrfp_pkg::BYTE_W-1:0] body_byte();
        logic [rrfp_pkg::BYTE_W-1:0] b;
        b = octet_t'($urandom_range(255));
        if (b == rrfp_pkg::TAIL_BYTE)
            b = ~b;
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------
    // One byte word; payload held until the DUT takes it.
    task automatic send_byte(input logic [rrfp_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        track_byte(b);
        bytes_sent++;
    endtask

    // Sender stops until every owed distance has come out, then idles a bit.
    task automatic wait_results(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Id register write; only called with the parser idle.
    task automatic write_id(input logic [rrfp_pkg::ID_W-1:0] id);
        cfg_valid           <= 1'b1;
        expected_message_id <= id;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        frm_want_id = id;
    endtask

    task automatic set_idling(input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    // Standard 14-byte frame. lone_hdr drops the second header, break_at (a
    // filler index, or -1) turns that filler into 0x55 followed by a dropped
    // byte, and extra pads the body to a wrong length.
    task automatic send_frame(input logic [rrfp_pkg::ID_W-1:0] id,
                              input logic [rrfp_pkg::DIST_W-1:0] range_val,
                              input bit lone_hdr, input int break_at, input int extra);
        logic [rrfp_pkg::BYTE_W-1:0] fb [14];
        foreach (fb[k])
            fb[k] = body_byte();
        fb[0]  = rrfp_pkg::HDR_BYTE;
        fb[1]  = rrfp_pkg::HDR_BYTE;
        fb[2]  = id[7:0];
        fb[3]  = id[15:8];
        fb[6]  = range_val[15:8];
        fb[7]  = range_val[7:0];
        fb[12] = rrfp_pkg::TAIL_BYTE;
        fb[13] = rrfp_pkg::TAIL_BYTE;
        for (int i = 0; i < 14; i++)
        begin
            if (i == 1 && lone_hdr)
                continue;
            if (i == break_at)
            begin
                send_byte(rrfp_pkg::TAIL_BYTE);
                send_byte(body_byte());
            end
            else
                send_byte(fb[i]);
            if (i == 11)
                repeat (extra) send_byte(body_byte());
        end
    endtask

    // Header, n tail-free body bytes, double tail.
    task automatic send_long_frame(input int n);
        send_byte(rrfp_pkg::HDR_BYTE);
        send_byte(rrfp_pkg::HDR_BYTE);
        repeat (n) send_byte(body_byte());
        send_byte(rrfp_pkg::TAIL_BYTE);
        send_byte(rrfp_pkg::TAIL_BYTE);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stall and result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dist.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected distance word: expected none, got %0d", range_cm);
                mismatches++;
            end
            else
            begin
                head_dist = pending_dist.pop_front();
                if (range_cm !== head_dist)
                begin
                    if (mismatches < 10)
                        $display("range_cm mismatch: expected %0d, got %0d",
                                 head_dist, range_cm);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: restarts on any word crossing any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset id, distance extremes.
    task automatic test_reset_id();
        send_frame(rrfp_pkg::ID_RESET, 16'h0000, 1'b0, -1, 0);
        send_frame(rrfp_pkg::ID_RESET, 16'hFFFF, 1'b0, -1, 0);
    endtask

    // Id extremes plus a near-miss id.
    task automatic test_id_extremes();
        wait_results(SETTLE_CYCLES);
        write_id(16'h0000);
        send_frame(16'h0000, 16'hFFFF, 1'b0, -1, 0);
        send_frame(16'h0001, 16'h1234, 1'b0, -1, 0);
        wait_results(SETTLE_CYCLES);
        write_id(16'hFFFF);
        send_frame(16'hFFFF, 16'h0000, 1'b0, -1, 0);
        send_frame(16'hFFFE, 16'h00FF, 1'b0, -1, 0);
    endtask

    // Lone header, including 0x55 right behind it (taken as the id low byte).
    task automatic test_lone_header();
        wait_results(SETTLE_CYCLES);
        write_id(16'h1255);
        send_frame(16'h1255, 16'hA5C3, 1'b1, -1, 0);
        send_frame(16'h1255, 16'h0102, 1'b0, -1, 0);    // 0x55 in body breaks this one
        wait_results(SETTLE_CYCLES);
        write_id(rrfp_pkg::ID_RESET);
        send_frame(rrfp_pkg::ID_RESET, 16'h3C5A, 1'b1, -1, 0);
    endtask

    // Single 0x55 inside a body, and bodies of the wrong length.
    task automatic test_broken_frames();
        send_frame(rrfp_pkg::ID_RESET, 16'h7E81, 1'b0, 9, 0);
        send_frame(rrfp_pkg::ID_RESET, 16'h1111, 1'b0, -1, 1);
        send_long_frame(4);
        send_frame(rrfp_pkg::ID_RESET, 16'h2222, 1'b0, -1, 0);
    endtask

    // Bodies running up to and past the fill limit.
    task automatic test_overlong();
        send_long_frame(48);
        send_long_frame(49);
        send_byte(rrfp_pkg::HDR_BYTE);
        send_byte(rrfp_pkg::HDR_BYTE);
        repeat (50) send_byte(body_byte());
        // fill is past the limit: this header restarts the hunt
        send_frame(rrfp_pkg::ID_RESET, 16'h4D2B, 1'b0, -1, 0);
    endtask

    task automatic random_traffic();
        int  start;
        int  pick;
        logic [rrfp_pkg::ID_W-1:0] id;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_frame(frm_want_id, {body_byte(), body_byte()},
                           $urandom_range(3) == 0, -1, 0);
            else if (pick < 73)
            begin
                id = {body_byte(), body_byte()};
                send_frame(id, {body_byte(), body_byte()}, 1'b0, -1, 0);
            end
            else if (pick < 80)
                send_frame(frm_want_id, {body_byte(), body_byte()}, 1'b0,
                           ($urandom_range(1) == 0) ? $urandom_range(4, 5)
                                                    : $urandom_range(8, 11), 0);
            else if (pick < 85)
                send_frame(frm_want_id, {body_byte(), body_byte()}, 1'b0, -1,
                           $urandom_range(1, 3));
            else if (pick < 89)
                send_long_frame($urandom_range(0, 1) == 0 ? $urandom_range(2, 12)
                                                          : $urandom_range(47, 52));
            else
                // line noise, heavy on header and tail bytes
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(3))
                        0:       send_byte(rrfp_pkg::HDR_BYTE);
                        1:       send_byte(rrfp_pkg::TAIL_BYTE);
                        default: send_byte(octet_t'($urandom_range(255)));
                    endcase
                end
            if ($urandom_range(24) == 0)
                wait_results(0);
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 4; p++)
        begin
            wait_results(SETTLE_CYCLES);
            write_id({body_byte(), body_byte()});
            case (p)
                0:       set_idling(0, 0);
                1:       set_idling(54, 0);
                2:       set_idling(0, 54);
                default: set_idling(29, 29);
            endcase
            random_traffic();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frm_phase   = rrfp_pkg::PH_HUNT;
        frm_fill    = '0;
        frm_id_lo   = '0;
        frm_id_hi   = '0;
        frm_rg_hi   = '0;
        frm_rg_lo   = '0;
        frm_want_id = rrfp_pkg::ID_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_id();
        test_id_extremes();
        test_lone_header();
        test_broken_frames();
        test_overlong();
        test_random_phases();

        set_idling(0, 0);
        wait_results(2 * SETTLE_CYCLES);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
